// File: hdl/qeti_pkg.sv
// Shared constants, command and status types for the escape-time iterator.
package qeti_pkg;

	// Number formats
	localparam int COORD_WIDTH   = 32;
	localparam int FRACTION_BITS = 28;
	localparam int COUNT_WIDTH   = 12;
	localparam int IN_WIDTH      = 31;
	localparam int PROD_WIDTH    = 2 * COORD_WIDTH;
	localparam int NEXT_WIDTH    = PROD_WIDTH - FRACTION_BITS + 2;

	localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	// Squared-magnitude escape bound: 4 at 2*FRACTION_BITS fraction bits
	localparam logic [PROD_WIDTH-1:0] ESCAPE_BOUND =
		PROD_WIDTH'(1) << (2 * FRACTION_BITS + 2);

	// Configuration register map
	localparam int CFG_INDEX_WIDTH = 2;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FRACTAL_MODE   = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_ITERATIONS = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_JULIA_C_REAL   = 2'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_JULIA_C_IMAG   = 2'd3;

	// Configuration reset values
	localparam logic                         MODE_RESET    = 1'b0;
	localparam logic [COUNT_WIDTH-1:0]       LIMIT_RESET   = COUNT_WIDTH'(100);
	localparam logic signed [IN_WIDTH-1:0]   C_REAL_RESET  = -31'sd200099842;
	localparam logic signed [IN_WIDTH-1:0]   C_IMAG_RESET  = 31'sd30335891;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;
		logic update;
		logic done;
		logic done_escaped;
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic escape;
		logic at_limit;
	} dp_stat_t;

endpackage

// File: hdl/qeti_dpath.sv
// Datapath: z and c registers, complex squaring, escape test, counter and result registers.
module qeti_dpath (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  qeti_pkg::dp_cmd_t                       cmd,
	output qeti_pkg::dp_stat_t                      stat,
	input  logic                                    mode,
	input  logic [qeti_pkg::COUNT_WIDTH-1:0]        limit,
	input  logic signed [qeti_pkg::IN_WIDTH-1:0]    julia_c_real,
	input  logic signed [qeti_pkg::IN_WIDTH-1:0]    julia_c_imag,
	input  logic signed [qeti_pkg::IN_WIDTH-1:0]    point_real,
	input  logic signed [qeti_pkg::IN_WIDTH-1:0]    point_imag,
	output logic                                    result_valid,
	output logic                                    escaped,
	output logic [qeti_pkg::COUNT_WIDTH-1:0]        iteration_count
);
	import qeti_pkg::*;

	logic signed [COORD_WIDTH-1:0] zr_q, zi_q, cr_q, ci_q;
	logic [COUNT_WIDTH-1:0]        count_q;
	logic signed [PROD_WIDTH-1:0]  sq_re_s1, sq_im_s1, cross_s1;
	logic [PROD_WIDTH-1:0]         mag_sum;
	logic signed [PROD_WIDTH-1:0]  diff;
	logic signed [NEXT_WIDTH-1:0]  re_next, im_next;
	logic signed [COORD_WIDTH-1:0] pr_ext, pi_ext, jr_ext, ji_ext;
	logic                          result_valid_q, escaped_q;
	logic [COUNT_WIDTH-1:0]        count_out_q;

	function automatic logic signed [COORD_WIDTH-1:0] widen(
		input logic signed [IN_WIDTH-1:0] v);
		return {{(COORD_WIDTH-IN_WIDTH){v[IN_WIDTH-1]}}, v};
	endfunction

	function automatic logic signed [NEXT_WIDTH-1:0] grow(
		input logic signed [COORD_WIDTH-1:0] v);
		return {{(NEXT_WIDTH-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
	endfunction

	// Clamp a wide update to the coordinate range
	function automatic logic signed [COORD_WIDTH-1:0] saturate(
		input logic signed [NEXT_WIDTH-1:0] v);
		logic [NEXT_WIDTH-COORD_WIDTH:0] top;
		top = v[NEXT_WIDTH-1:COORD_WIDTH-1];
		if ((&top) || !(|top))
			return v[COORD_WIDTH-1:0];
		else if (v[NEXT_WIDTH-1])
			return COORD_MIN;
		else
			return COORD_MAX;
	endfunction

	assign pr_ext = widen(point_real);
	assign pi_ext = widen(point_imag);
	assign jr_ext = widen(julia_c_real);
	assign ji_ext = widen(julia_c_imag);

	// Square stage: three products of the current z
	always_ff @(posedge clk) begin
		sq_re_s1 <= zr_q * zr_q;
		sq_im_s1 <= zi_q * zi_q;
		cross_s1 <= zr_q * zi_q;
	end

	// Escape test and next z from the registered products
	always_comb begin
		mag_sum = $unsigned(sq_re_s1) + $unsigned(sq_im_s1);
		diff    = sq_re_s1 - sq_im_s1;
		re_next = {{2{diff[PROD_WIDTH-1]}}, diff[PROD_WIDTH-1:FRACTION_BITS]} + grow(cr_q);
		im_next = {cross_s1[PROD_WIDTH-1], cross_s1[PROD_WIDTH-1:FRACTION_BITS-1]}
			+ grow(ci_q);
	end

	assign stat.escape   = mag_sum > ESCAPE_BOUND;
	assign stat.at_limit = count_q == limit;

	// Load the starting point or advance one step
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			zr_q    <= mode ? pr_ext : '0;
			zi_q    <= mode ? pi_ext : '0;
			cr_q    <= mode ? jr_ext : pr_ext;
			ci_q    <= mode ? ji_ext : pi_ext;
			count_q <= '0;
		end else if (cmd.update) begin
			zr_q    <= saturate(re_next);
			zi_q    <= saturate(im_next);
			count_q <= count_q + COUNT_WIDTH'(1);
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.done;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.done) begin
			escaped_q   <= cmd.done_escaped;
			count_out_q <= count_q;
		end
	end

	assign result_valid    = result_valid_q;
	assign escaped         = escaped_q;
	assign iteration_count = count_out_q;

`ifndef SYNTHESIS
	a_strobe_isolated: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !$past(result_valid))
		else $error("result strobes in consecutive cycles");
	a_update_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> !stat.at_limit)
		else $error("step taken at the iteration limit");
	a_plain_done_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.done && !cmd.done_escaped |-> stat.at_limit)
		else $error("non-escaped result before the limit");
`endif

endmodule

// File: hdl/qeti_ctrl.sv
// Controller: sequences load, square, evaluate and finish for one point.
module qeti_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  qeti_pkg::dp_stat_t  stat,
	output qeti_pkg::dp_cmd_t   cmd
);
	import qeti_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SQUARE = 2'd1;
	localparam logic [1:0] ST_EVAL   = 2'd2;

	logic [1:0] state_q, state_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				if (stat.at_limit) begin
					cmd.done = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (stat.escape) begin
					cmd.done         = 1'b1;
					cmd.done_escaped = 1'b1;
					state_d          = ST_IDLE;
				end else begin
					cmd.update = 1'b1;
					state_d    = ST_SQUARE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != ST_IDLE;

`ifndef SYNTHESIS
	a_load_alone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !cmd.update && !cmd.done)
		else $error("load issued together with another command");
	a_eval_after_square: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EVAL |-> $past(state_q) == ST_SQUARE)
		else $error("evaluate not preceded by square");
	a_done_leaves_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.done |=> !busy)
		else $error("still busy after result");
`endif

endmodule

// File: hdl/quadratic_escape_time_iterator_unit.sv
// Top level: configuration registers and the controller/datapath pair.
// A point accepted on start (with busy low) iterates z = z*z + c in signed Q4.28. Each
// iteration forms the three 32x32 products of z in SQUARE, then in EVAL tests the
// squared magnitude against 4 and writes the saturated next z. The result is registered
// from the EVAL state that sees the escape or the SQUARE state that finds the count at
// the limit L. It is on escaped and iteration_count, marked by result_valid for exactly
// one cycle, and cannot be held off; busy is already low in that cycle, so the next
// point may be accepted then. The user must write configuration through cfg_write,
// cfg_index and cfg_data only while busy is low; the block itself does not enforce it.
module quadratic_escape_time_iterator_unit (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	output logic                                        busy,
	input  logic signed [qeti_pkg::IN_WIDTH-1:0]        point_real,
	input  logic signed [qeti_pkg::IN_WIDTH-1:0]        point_imag,
	input  logic                                        cfg_write,
	input  logic [qeti_pkg::CFG_INDEX_WIDTH-1:0]        cfg_index,
	input  logic [qeti_pkg::IN_WIDTH-1:0]               cfg_data,
	output logic                                        result_valid,
	output logic                                        escaped,
	output logic [qeti_pkg::COUNT_WIDTH-1:0]            iteration_count
);
	import qeti_pkg::*;

	logic                         mode_q;
	logic [COUNT_WIDTH-1:0]       limit_q;
	logic signed [IN_WIDTH-1:0]   c_real_q, c_imag_q;
	dp_cmd_t                      cmd;
	dp_stat_t                     stat;

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_RESET;
			limit_q  <= LIMIT_RESET;
			c_real_q <= C_REAL_RESET;
			c_imag_q <= C_IMAG_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_FRACTAL_MODE:   mode_q   <= cfg_data[0];
				CFG_MAX_ITERATIONS: limit_q  <= cfg_data[COUNT_WIDTH-1:0];
				CFG_JULIA_C_REAL:   c_real_q <= cfg_data;
				CFG_JULIA_C_IMAG:   c_imag_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	qeti_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	qeti_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.mode            (mode_q),
		.limit           (limit_q),
		.julia_c_real    (c_real_q),
		.julia_c_imag    (c_imag_q),
		.point_real      (point_real),
		.point_imag      (point_imag),
		.result_valid    (result_valid),
		.escaped         (escaped),
		.iteration_count (iteration_count)
	);

endmodule
